// File: rtl/core/ptrl_pkg.sv
// types, constants and helper functions shared by the price table core
// no dependencies; every other file in rtl/core imports this package
`default_nettype none

package ptrl_pkg;

   localparam int SLOTS            = 96;
   localparam int SLOTS_PER_HOUR   = 4;
   localparam int HOURS_PER_DAY    = 24;
   localparam int MINUTES_PER_SLOT = 15;

   localparam int PRICE_W   = 24;
   localparam int RANK_W    = 7;
   localparam int SPLIT_W   = 7;
   localparam int HOUR_W    = 6;
   localparam int MINUTE_W  = 6;
   localparam int OP_W      = 3;
   localparam int CSR_IDX_W = 3;

   localparam int ADDR_W     = $clog2(SLOTS);
   localparam int CNT_W      = $clog2(SLOTS + 1);
   localparam int BIT_W      = $clog2(PRICE_W);
   localparam int WRAP_HOURS = (1 << HOUR_W) - HOURS_PER_DAY;
   localparam int AVG_SPAN   = WRAP_HOURS * SLOTS_PER_HOUR;
   localparam int IDX_W      = $clog2(((SLOTS > AVG_SPAN) ? SLOTS : AVG_SPAN) + 1);
   localparam int MAX_Q      = ((1 << MINUTE_W) - 1) / MINUTES_PER_SLOT;
   localparam int Q_W        = $clog2(MAX_Q + 1);
   localparam int AVG_SHIFT  = $clog2(SLOTS_PER_HOUR);
   localparam int SUM_W      = PRICE_W + AVG_SHIFT;

   localparam logic signed [PRICE_W-1:0] PRICE_MAX   = {1'b0, {(PRICE_W-1){1'b1}}};
   localparam logic signed [PRICE_W-1:0] PRICE_MIN   = {1'b1, {(PRICE_W-1){1'b0}}};
   localparam logic signed [PRICE_W-1:0] PRICE_RESET = PRICE_W'(13107);

   localparam logic [RANK_W-1:0]         SELECT_RANK_RST    = RANK_W'(24);
   localparam logic signed [PRICE_W-1:0] LIMIT_MARGIN_RST   = PRICE_W'(328);
   localparam logic signed [PRICE_W-1:0] DEFAULT_PRICE_RST  = PRICE_W'(13107);
   localparam logic signed [PRICE_W-1:0] FALLBACK_LOW_RST   = PRICE_W'(3932);
   localparam logic signed [PRICE_W-1:0] FALLBACK_HIGH_RST  = PRICE_W'(7864);
   localparam logic [SPLIT_W-1:0]        FALLBACK_SPLIT_RST = SPLIT_W'(24);
   localparam logic signed [PRICE_W-1:0] FALLBACK_LIMIT_RST = PRICE_W'(6554);
   localparam logic signed [PRICE_W-1:0] ERROR_PRICE_RST    = PRICE_W'(64881);

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR,
      OP_WRITE,
      OP_LIMIT,
      OP_AVERAGE,
      OP_READ,
      OP_FALLBACK,
      OP_SET_LIMIT,
      OP_NOP
   } ptrl_op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SELECT_RANK,
      CSR_LIMIT_MARGIN,
      CSR_DEFAULT_PRICE,
      CSR_FALLBACK_LOW,
      CSR_FALLBACK_HIGH,
      CSR_FALLBACK_SPLIT,
      CSR_FALLBACK_LIMIT,
      CSR_ERROR_PRICE
   } ptrl_csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SWEEP,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE,
      ST_FINISH,
      ST_RESP
   } ptrl_state_type;

   typedef struct packed {
      logic [RANK_W-1:0]         select_rank;
      logic signed [PRICE_W-1:0] limit_margin;
      logic signed [PRICE_W-1:0] default_price;
      logic signed [PRICE_W-1:0] fallback_low;
      logic signed [PRICE_W-1:0] fallback_high;
      logic [SPLIT_W-1:0]        fallback_split;
      logic signed [PRICE_W-1:0] fallback_limit;
      logic signed [PRICE_W-1:0] error_price;
   } ptrl_cfg_type;

   typedef struct packed {
      logic                      we;
      logic [ADDR_W-1:0]         waddr;
      logic signed [PRICE_W-1:0] wdata;
      logic                      re;
      logic [ADDR_W-1:0]         raddr;
   } ptrl_mem_req_type;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] idx;
   } ptrl_slot_type;

   function automatic ptrl_slot_type slot_of(input logic [HOUR_W-1:0]   hour,
                                             input logic [MINUTE_W-1:0] minute);
      ptrl_slot_type    s;
      logic [Q_W-1:0]   q;
      logic [IDX_W-1:0] idx;
      q = '0;
      for (int k = 1; k <= MAX_Q; k++) begin
         if (minute >= MINUTE_W'(k * MINUTES_PER_SLOT)) q = q + Q_W'(1);
      end
      idx     = IDX_W'(hour) * IDX_W'(SLOTS_PER_HOUR) + IDX_W'(q);
      s.valid = (hour < HOUR_W'(HOURS_PER_DAY)) && (idx < IDX_W'(SLOTS));
      s.idx   = idx;
      return s;
   endfunction

   // maps signed order onto unsigned order and back
   function automatic logic [PRICE_W-1:0] flip_sign(input logic [PRICE_W-1:0] p);
      return {~p[PRICE_W-1], p[PRICE_W-2:0]};
   endfunction

   function automatic logic signed [PRICE_W-1:0] sat_add(input logic signed [PRICE_W-1:0] a,
                                                         input logic signed [PRICE_W-1:0] b);
      logic [PRICE_W:0] s;
      s = {a[PRICE_W-1], a} + {b[PRICE_W-1], b};
      if (s[PRICE_W] != s[PRICE_W-1]) return s[PRICE_W] ? PRICE_MIN : PRICE_MAX;
      return s[PRICE_W-1:0];
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/ptrl_store.sv
// price table storage: synchronous ram with one write port and one read port, registered read data
// per-slot valid bits make never-written slots read as the reset price; uses ptrl_pkg
`default_nettype none

module ptrl_store import ptrl_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  ptrl_mem_req_type          mem_req,
   output logic signed [PRICE_W-1:0] rdata
);

   logic signed [PRICE_W-1:0] mem [SLOTS];
   logic [SLOTS-1:0]          vld_ff;
   logic signed [PRICE_W-1:0] rdata_ff;
   logic                      rvld_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr] <= mem_req.wdata;
      end
      if (mem_req.re) begin
         rdata_ff <= mem[mem_req.raddr];
         rvld_ff  <= vld_ff[mem_req.raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (mem_req.we) begin
         vld_ff[mem_req.waddr] <= 1'b1;
      end
   end

   assign rdata = rvld_ff ? rdata_ff : PRICE_RESET;

endmodule

`default_nettype wire

// File: rtl/core/ptrl_ctrl.sv
// request sequencer: table sweeps, slot access, hour average and radix rank select
// drives the ptrl_store port and holds the limit; uses ptrl_pkg
`default_nettype none

module ptrl_ctrl import ptrl_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [OP_W-1:0]           req_opcode,
   input  logic [HOUR_W-1:0]         req_hour,
   input  logic [MINUTE_W-1:0]       req_minute,
   input  logic signed [PRICE_W-1:0] req_price,
   input  ptrl_cfg_type              cfg,
   output ptrl_mem_req_type          mem_req,
   input  logic signed [PRICE_W-1:0] mem_rdata,
   output logic                      rsp_valid,
   output logic signed [PRICE_W-1:0] rsp_value,
   output logic signed [PRICE_W-1:0] rsp_limit
);

   ptrl_state_type            state_ff, state_in;
   ptrl_op_type               op_ff, op_in;
   logic [HOUR_W-1:0]         hour_ff, hour_in;
   logic [MINUTE_W-1:0]       minute_ff, minute_in;
   logic signed [PRICE_W-1:0] price_ff, price_in;
   logic [IDX_W-1:0]          addr_ff, addr_in;
   logic [CNT_W-1:0]          left_ff, left_in;
   logic                      pend_ff, pend_in;
   logic                      inrng_ff, inrng_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [CNT_W-1:0]          krem_ff, krem_in;
   logic [PRICE_W-1:0]        prefix_ff, prefix_in;
   logic [BIT_W-1:0]          bit_ff, bit_in;
   logic signed [PRICE_W-1:0] value_ff, value_in;
   logic signed [PRICE_W-1:0] limit_ff, limit_in;

   ptrl_slot_type             slot;
   logic [HOUR_W-1:0]         avg_hour;
   logic [IDX_W-1:0]          avg_base;
   logic                      rank_ok;
   logic                      addr_ok;
   logic [PRICE_W-1:0]        rd_key;
   logic [PRICE_W-1:0]        hi_mask;
   logic                      match;
   logic                      take_zero;
   logic signed [PRICE_W-1:0] sat_limit;
   logic signed [PRICE_W-1:0] sweep_data;
   logic signed [PRICE_W-1:0] avg_value;

   assign slot     = slot_of(hour_ff, minute_ff);
   assign avg_hour = (hour_ff >= HOUR_W'(HOURS_PER_DAY)) ?
                     hour_ff - HOUR_W'(HOURS_PER_DAY) : hour_ff;
   assign avg_base = IDX_W'(avg_hour) * IDX_W'(SLOTS_PER_HOUR);
   assign rank_ok  = 32'(cfg.select_rank) < 32'(SLOTS);
   assign addr_ok  = addr_ff < IDX_W'(SLOTS);

   // radix select: count entries sharing the decided high bits with a zero at bit_ff
   assign rd_key    = flip_sign(mem_rdata);
   assign hi_mask   = ~((PRICE_W'(2) << bit_ff) - PRICE_W'(1));
   assign match     = (((rd_key ^ prefix_ff) & hi_mask) == '0) && !rd_key[bit_ff];
   assign take_zero = krem_ff < cnt_ff;
   assign sat_limit = sat_add(flip_sign(prefix_ff), cfg.limit_margin);

   assign sweep_data = (op_ff == OP_CLEAR) ? cfg.default_price :
                       (32'(addr_ff) < 32'(cfg.fallback_split)) ? cfg.fallback_low :
                       cfg.fallback_high;
   assign avg_value  = PRICE_W'(sum_ff >>> AVG_SHIFT);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            case (op_ff)
               OP_CLEAR, OP_FALLBACK: state_in = ST_SWEEP;
               OP_LIMIT:              state_in = rank_ok ? ST_SCAN : ST_RESP;
               OP_AVERAGE:            state_in = ST_SCAN;
               OP_READ:               state_in = slot.valid ? ST_SCAN : ST_RESP;
               default:               state_in = ST_RESP;
            endcase
         end
         ST_SWEEP: begin
            if (addr_ff == IDX_W'(SLOTS - 1)) state_in = ST_RESP;
         end
         ST_SCAN: begin
            if (left_ff == CNT_W'(1)) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (op_ff == OP_LIMIT) begin
               state_in = (bit_ff == '0) ? ST_FINISH : ST_SCAN;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_FINISH: state_in = ST_RESP;
         ST_RESP:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs and memory port
   always_comb begin
      busy      = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_RESP);
      mem_req   = '0;
      case (state_ff)
         ST_EXEC: begin
            if (op_ff == OP_WRITE && slot.valid) begin
               mem_req.we    = 1'b1;
               mem_req.waddr = slot.idx[ADDR_W-1:0];
               mem_req.wdata = price_ff;
            end
         end
         ST_SWEEP: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = addr_ff[ADDR_W-1:0];
            mem_req.wdata = sweep_data;
         end
         ST_SCAN: begin
            mem_req.re    = addr_ok;
            mem_req.raddr = addr_ff[ADDR_W-1:0];
         end
         default: ;
      endcase
   end

   // datapath next values
   always_comb begin
      op_in     = op_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      price_in  = price_ff;
      addr_in   = addr_ff;
      left_in   = left_ff;
      sum_in    = sum_ff;
      cnt_in    = cnt_ff;
      krem_in   = krem_ff;
      prefix_in = prefix_ff;
      bit_in    = bit_ff;
      value_in  = value_ff;
      limit_in  = limit_ff;
      pend_in   = (state_ff == ST_SCAN);
      inrng_in  = addr_ok;

      if (start && state_ff == ST_IDLE) begin
         op_in     = ptrl_op_type'(req_opcode);
         hour_in   = req_hour;
         minute_in = req_minute;
         price_in  = req_price;
      end

      // read data lands in the cycle after the scan issues it
      if (pend_ff) begin
         if (op_ff == OP_LIMIT) begin
            if (match) cnt_in = cnt_ff + CNT_W'(1);
         end else if (inrng_ff) begin
            sum_in = sum_ff + SUM_W'(mem_rdata);
         end
      end

      case (state_ff)
         ST_EXEC: begin
            value_in  = '0;
            sum_in    = '0;
            cnt_in    = '0;
            addr_in   = '0;
            left_in   = CNT_W'(SLOTS);
            prefix_in = '0;
            bit_in    = BIT_W'(PRICE_W - 1);
            krem_in   = CNT_W'(cfg.select_rank);
            case (op_ff)
               OP_AVERAGE: begin
                  addr_in = avg_base;
                  left_in = CNT_W'(SLOTS_PER_HOUR);
               end
               OP_READ: begin
                  addr_in = slot.idx;
                  left_in = CNT_W'(1);
                  if (!slot.valid) value_in = cfg.error_price;
               end
               OP_LIMIT: begin
                  if (!rank_ok) value_in = limit_ff;
               end
               OP_FALLBACK:  limit_in = cfg.fallback_limit;
               OP_SET_LIMIT: limit_in = price_ff;
               default: ;
            endcase
         end
         ST_SWEEP: begin
            addr_in = addr_ff + IDX_W'(1);
         end
         ST_SCAN: begin
            addr_in = addr_ff + IDX_W'(1);
            left_in = left_ff - CNT_W'(1);
         end
         ST_DECIDE: begin
            if (op_ff == OP_LIMIT) begin
               if (!take_zero) begin
                  prefix_in[bit_ff] = 1'b1;
                  krem_in           = krem_ff - cnt_ff;
               end
               bit_in  = bit_ff - BIT_W'(1);
               cnt_in  = '0;
               addr_in = '0;
               left_in = CNT_W'(SLOTS);
            end else if (op_ff == OP_AVERAGE) begin
               value_in = avg_value;
            end else begin
               value_in = PRICE_W'(sum_ff);
            end
         end
         ST_FINISH: begin
            value_in = sat_limit;
            limit_in = sat_limit;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
         limit_ff <= '0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         limit_ff <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      hour_ff   <= hour_in;
      minute_ff <= minute_in;
      price_ff  <= price_in;
      addr_ff   <= addr_in;
      left_ff   <= left_in;
      inrng_ff  <= inrng_in;
      sum_ff    <= sum_in;
      cnt_ff    <= cnt_in;
      krem_ff   <= krem_in;
      prefix_ff <= prefix_in;
      bit_ff    <= bit_in;
      value_ff  <= value_in;
   end

   assign rsp_value = value_ff;
   assign rsp_limit = limit_ff;

endmodule

`default_nettype wire

// File: rtl/core/price_table_rank_limit_core.sv
// write, set limit, no-op, out-of-range read and out-of-range rank respond without a table
// pass; slot read scans one slot, hour average SLOTS_PER_HOUR slots, clear and fallback
// write all SLOTS slots; rank limit makes one pass over the table per price bit through
// the single table read port. one request at a time: busy stays high through the
// one-cycle rsp_valid strobe and the next request is taken the cycle after. synchronous
// reset restores registers and table to power-on prices and clears the limit, no clearing pass
`default_nettype none

module price_table_rank_limit_core import ptrl_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [OP_W-1:0]             req_opcode,
   input  logic [HOUR_W-1:0]           req_hour,
   input  logic [MINUTE_W-1:0]         req_minute,
   input  logic signed [PRICE_W-1:0]   req_price,
   output logic                        rsp_valid,
   output logic signed [PRICE_W-1:0]   rsp_value,
   output logic signed [PRICE_W-1:0]   rsp_limit,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [PRICE_W-1:0]          csr_data
);

   ptrl_cfg_type              cfg_ff;
   ptrl_mem_req_type          mem_req;
   logic signed [PRICE_W-1:0] mem_rdata;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.select_rank    <= SELECT_RANK_RST;
         cfg_ff.limit_margin   <= LIMIT_MARGIN_RST;
         cfg_ff.default_price  <= DEFAULT_PRICE_RST;
         cfg_ff.fallback_low   <= FALLBACK_LOW_RST;
         cfg_ff.fallback_high  <= FALLBACK_HIGH_RST;
         cfg_ff.fallback_split <= FALLBACK_SPLIT_RST;
         cfg_ff.fallback_limit <= FALLBACK_LIMIT_RST;
         cfg_ff.error_price    <= ERROR_PRICE_RST;
      end else if (csr_valid && csr_ready) begin
         case (ptrl_csr_type'(csr_index))
            CSR_SELECT_RANK:    cfg_ff.select_rank    <= csr_data[RANK_W-1:0];
            CSR_LIMIT_MARGIN:   cfg_ff.limit_margin   <= csr_data;
            CSR_DEFAULT_PRICE:  cfg_ff.default_price  <= csr_data;
            CSR_FALLBACK_LOW:   cfg_ff.fallback_low   <= csr_data;
            CSR_FALLBACK_HIGH:  cfg_ff.fallback_high  <= csr_data;
            CSR_FALLBACK_SPLIT: cfg_ff.fallback_split <= csr_data[SPLIT_W-1:0];
            CSR_FALLBACK_LIMIT: cfg_ff.fallback_limit <= csr_data;
            CSR_ERROR_PRICE:    cfg_ff.error_price    <= csr_data;
            default: ;
         endcase
      end
   end

   ptrl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_opcode (req_opcode),
      .req_hour   (req_hour),
      .req_minute (req_minute),
      .req_price  (req_price),
      .cfg        (cfg_ff),
      .mem_req    (mem_req),
      .mem_rdata  (mem_rdata),
      .rsp_valid  (rsp_valid),
      .rsp_value  (rsp_value),
      .rsp_limit  (rsp_limit)
   );

   ptrl_store u_store (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rdata   (mem_rdata)
   );

endmodule

`default_nettype wire

// File: rtl/core/ptrl_checker.sv
// port-level checks on request/response sequencing of the price table core
// bound to price_table_rank_limit_core; uses ptrl_pkg
`default_nettype none

module ptrl_checker import ptrl_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input logic                      rsp_valid,
   input logic signed [PRICE_W-1:0] rsp_limit
);

   // an accepted request keeps the core busy into the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but core not busy");

   a_rsp_in_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("response while idle");

   // the response ends the request
   a_rsp_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!busy && !rsp_valid))
      else $error("core still busy after response");

   // limit only moves while a request is in flight
   a_limit_hold: assert property (@(posedge clock) disable iff (reset)
      !busy |=> $stable(rsp_limit))
      else $error("limit changed while idle");

endmodule

bind price_table_rank_limit_core ptrl_checker u_ptrl_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_limit (rsp_limit)
);

`default_nettype wire
